// ===== hw/rtl/lcs_pkg.sv =====
package lcs_pkg;

  // Field geometry
  localparam int COLUMNS = 64;
  localparam int ROWS    = 16;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int RIDX_W  = $clog2(ROWS);

  // Beat field widths
  localparam int SPAWN_COL_W = 6;
  localparam int SPAWN_ROW_W = 4;
  localparam int LEVEL_W     = 2;
  localparam int RND_W       = 8;
  localparam int IDX_W       = 6;
  localparam int OUT_ROWS    = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int OFF_COL_W  = 6;
  localparam int OFF_ROW_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_OFF_COL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_ROW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_KILL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_EN   = 2'd3;

  // Command codes of an input beat
  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_SPAWN   = 1'b1;

  // Life rule B3/S23
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Border rows cleared by edge kill
  localparam logic [ROWS-1:0] EDGE_ROWS = {1'b1, {(ROWS-2){1'b0}}, 1'b1};

  // Controller to datapath commands
  typedef struct packed {
    logic take_item;
    logic rd_pre;
    logic rd_adv;
    logic ld_old;
    logic emit_one;
    logic emit_zero;
    logic emit_cur;
    logic wr_adv;
    logic sp_rd;
    logic sp_wr;
    logic kill_rd;
    logic kill_wr;
  } lcs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_spawn;
    logic ptr_one;
    logic ptr_last;
    logic edge_kill;
    logic out_free;
    logic sp_more;
    logic kill_done;
  } lcs_sts_t;

  // Zero-extend or truncate a column number to the result index width
  function automatic logic [IDX_W-1:0] to_out_idx(input logic [COL_W-1:0] c);
    logic [IDX_W+COL_W-1:0] w;
    w = {{IDX_W{1'b0}}, c};
    return w[IDX_W-1:0];
  endfunction

  // Keep the low result rows of a column
  function automatic logic [OUT_ROWS-1:0] to_out_bits(input logic [ROWS-1:0] c);
    logic [OUT_ROWS+ROWS-1:0] w;
    w = {{OUT_ROWS{1'b0}}, c};
    return w[OUT_ROWS-1:0];
  endfunction

endpackage

// ===== hw/rtl/lcs_in_if.sv =====
interface lcs_in_if;
  import lcs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [SPAWN_COL_W-1:0] spawn_col;
  logic [SPAWN_ROW_W-1:0] spawn_row;
  logic [LEVEL_W-1:0]     spawn_level;
  logic [RND_W-1:0]       random_bits;

  modport source (
    output valid, cmd, spawn_col, spawn_row, spawn_level, random_bits,
    input  ready
  );

  modport sink (
    input  valid, cmd, spawn_col, spawn_row, spawn_level, random_bits,
    output ready
  );

endinterface

// ===== hw/rtl/lcs_out_if.sv =====
interface lcs_out_if;
  import lcs_pkg::*;

  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    column_index;
  logic [OUT_ROWS-1:0] column_bits;
  logic                last;

  modport source (
    output valid, column_index, column_bits, last,
    input  ready
  );

  modport sink (
    input  valid, column_index, column_bits, last,
    output ready
  );

endinterface

// ===== hw/rtl/lcs_datapath.sv =====
module lcs_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lcs_pkg::lcs_cmd_t               cmd,
  output lcs_pkg::lcs_sts_t               sts,
  input  logic                            item_cmd,
  input  logic [lcs_pkg::SPAWN_COL_W-1:0] item_spawn_col,
  input  logic [lcs_pkg::SPAWN_ROW_W-1:0] item_spawn_row,
  input  logic [lcs_pkg::LEVEL_W-1:0]     item_spawn_level,
  input  logic [lcs_pkg::RND_W-1:0]       item_random_bits,
  input  logic                            cfg_we,
  input  logic [lcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            res_valid,
  output logic [lcs_pkg::IDX_W-1:0]       res_column_index,
  output logic [lcs_pkg::OUT_ROWS-1:0]    res_column_bits,
  output logic                            res_last,
  input  logic                            res_ready
);
  import lcs_pkg::*;

  // Field memory and per-column valid bits
  logic [ROWS-1:0]    field_mem [COLUMNS];
  logic [COLUMNS-1:0] vld_r;
  logic [ROWS-1:0]    rd_raw_a_r, rd_raw_b_r;
  logic               rd_vld_a_r, rd_vld_b_r;
  logic [ROWS-1:0]    rd_a, rd_b;
  logic               rd_en;
  logic [COL_W-1:0]   rd_addr_a, rd_addr_b;
  logic               wr_en;
  logic [COL_W-1:0]   wr_addr;
  logic [ROWS-1:0]    wr_data;

  // Sweep state
  logic [COL_W-1:0] ptr_r, ptr_inc, kill_cnt_r;
  logic [ROWS-1:0]  left_r, this_r;
  logic             ptr_last;

  // Configuration
  logic [OFF_COL_W-1:0] off_col_r;
  logic [OFF_ROW_W-1:0] off_row_r;
  logic                 edge_kill_r, ring_en_r;

  // Spawn state
  logic [SPAWN_COL_W-1:0] sp_col_r;
  logic [SPAWN_ROW_W-1:0] sp_row_r;
  logic [LEVEL_W-1:0]     sp_level_r;
  logic [RND_W-1:0]       sp_rnd_r;
  logic [2:0]             sp_i_r;
  logic [5:0]             sp_nbase_r;
  logic [ROWS-1:0]        sp_mask_r, sp_mask;
  logic [COL_W-1:0]       sp_addr_r, sp_addr;
  logic                   sp_ok_r, sp_ok;
  logic [LEVEL_W-1:0]     r_eff;
  logic [2:0]             span;
  logic [6:0]             cx_u;
  logic [4:0]             cy_u;
  logic signed [9:0]      col_s;

  // Life update and edge kill data
  logic [ROWS-1:0] right, new_col, kill_data;

  // Result register
  logic                vld_out_r;
  logic [IDX_W-1:0]    idx_out_r;
  logic [OUT_ROWS-1:0] bits_out_r;
  logic                last_out_r;
  logic                push;
  logic [COL_W-1:0]    push_idx;
  logic [ROWS-1:0]     push_bits;

  assign ptr_inc  = ptr_r + COL_W'(1);
  assign ptr_last = (ptr_r == COL_W'(COLUMNS - 1));

  // Select read addresses
  always_comb begin
    rd_addr_a = ptr_r;
    rd_addr_b = ptr_last ? '0 : ptr_inc;
    if (cmd.rd_pre) begin
      rd_addr_a = '0;
      rd_addr_b = COL_W'(1);
    end
    if (cmd.sp_rd) rd_addr_a = sp_addr;
    if (cmd.kill_rd) rd_addr_a = kill_cnt_r;
  end

  assign rd_en = cmd.rd_pre | cmd.rd_adv | cmd.sp_rd | cmd.kill_rd;

  // Memory array, registered reads
  always_ff @(posedge clk) begin
    if (wr_en) field_mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_raw_a_r <= field_mem[rd_addr_a];
      rd_raw_b_r <= field_mem[rd_addr_b];
    end
  end

  // Valid bits: an unwritten column reads dead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      rd_vld_a_r <= 1'b0;
      rd_vld_b_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (rd_en) begin
        rd_vld_a_r <= vld_r[rd_addr_a];
        rd_vld_b_r <= vld_r[rd_addr_b];
      end
    end
  end

  assign rd_a = rd_vld_a_r ? rd_raw_a_r : '0;
  assign rd_b = rd_vld_b_r ? rd_raw_b_r : '0;

  // Compute the updated column from the two old columns and the next one
  assign right = ptr_last ? '0 : rd_b;

  always_comb begin
    logic [ROWS+1:0] lp, tp, rp;
    logic [3:0]      n;
    lp = {1'b0, left_r, 1'b0};
    tp = {1'b0, this_r, 1'b0};
    rp = {1'b0, right, 1'b0};
    new_col = rd_a;
    for (int y = 1; y < ROWS; y++) begin
      n = {3'b0, lp[y]} + {3'b0, lp[y+1]} + {3'b0, lp[y+2]}
        + {3'b0, tp[y]} + {3'b0, tp[y+2]}
        + {3'b0, rp[y]} + {3'b0, rp[y+1]} + {3'b0, rp[y+2]};
      new_col[y] = (n == BIRTH_COUNT) | (tp[y+1] & (n == SURVIVE_COUNT) & rd_a[y]);
    end
  end

  // Clear border rows; whole first and last columns
  assign kill_data = ((kill_cnt_r == '0) || (kill_cnt_r == COL_W'(COLUMNS - 1)))
                   ? '0 : (rd_a & ~EDGE_ROWS);

  // Spawn column address and row mask for the current ring column
  assign r_eff = ring_en_r ? sp_level_r : '0;
  assign span  = {r_eff, 1'b0};
  assign cx_u  = {1'b0, sp_col_r} + {1'b0, off_col_r};
  assign cy_u  = {1'b0, sp_row_r} + {1'b0, off_row_r};
  assign col_s = $signed({3'b0, cx_u}) - $signed({8'b0, r_eff}) + $signed({7'b0, sp_i_r});
  assign sp_ok = (col_s >= 10'sd0) && (col_s < $signed(10'(COLUMNS)));
  assign sp_addr = sp_ok ? col_s[COL_W-1:0] : '0;

  always_comb begin
    logic [5:0]        n;
    logic signed [6:0] row_s;
    logic              hit;
    sp_mask = '0;
    for (int j = 0; j < 7; j++) begin
      n     = sp_nbase_r + 6'(j);
      row_s = $signed({2'b0, cy_u}) - $signed({5'b0, r_eff}) + $signed(7'(j));
      hit   = ring_en_r && (r_eff != '0) && (3'(j) <= span) && !n[3] && sp_rnd_r[n[2:0]];
      if (hit && (row_s >= 7'sd0) && (row_s < $signed(7'(ROWS))))
        sp_mask[row_s[RIDX_W-1:0]] = 1'b1;
    end
    // centre cell is set whatever the ring bits say
    if ((sp_i_r == {1'b0, r_eff}) && ({1'b0, cy_u} < 6'(ROWS)))
      sp_mask[cy_u[RIDX_W-1:0]] = 1'b1;
  end

  // Select the write port
  always_comb begin
    wr_en   = cmd.wr_adv;
    wr_addr = ptr_r;
    wr_data = new_col;
    if (cmd.sp_wr) begin
      wr_en   = sp_ok_r;
      wr_addr = sp_addr_r;
      wr_data = rd_a | sp_mask_r;
    end
    if (cmd.kill_wr) begin
      wr_en   = 1'b1;
      wr_addr = kill_cnt_r;
      wr_data = kill_data;
    end
  end

  // Sweep pointer, saved old columns and kill counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= COL_W'(1);
      left_r     <= '0;
      this_r     <= '0;
      kill_cnt_r <= '0;
    end else begin
      if (cmd.ld_old) begin
        left_r <= rd_a;
        this_r <= rd_b;
      end
      if (cmd.wr_adv) begin
        left_r     <= this_r;
        this_r     <= right;
        ptr_r      <= ptr_last ? COL_W'(1) : ptr_inc;
        kill_cnt_r <= '0;
      end
      if (cmd.kill_wr) kill_cnt_r <= kill_cnt_r + COL_W'(1);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_col_r   <= '0;
      off_row_r   <= '0;
      edge_kill_r <= 1'b0;
      ring_en_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFF_COL:   off_col_r   <= cfg_data[OFF_COL_W-1:0];
        CFG_OFF_ROW:   off_row_r   <= cfg_data[OFF_ROW_W-1:0];
        CFG_EDGE_KILL: edge_kill_r <= cfg_data[0];
        CFG_RING_EN:   ring_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Spawn step counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_i_r     <= '0;
      sp_nbase_r <= '0;
    end else if (cmd.take_item) begin
      sp_i_r     <= '0;
      sp_nbase_r <= '0;
    end else if (cmd.sp_wr) begin
      sp_i_r     <= sp_i_r + 3'd1;
      sp_nbase_r <= sp_nbase_r + {3'b0, span} + 6'd1;
    end
  end

  // Hold the spawn beat and the mask of the column being read
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      sp_col_r   <= item_spawn_col;
      sp_row_r   <= item_spawn_row;
      sp_level_r <= item_spawn_level;
      sp_rnd_r   <= item_random_bits;
    end
    if (cmd.sp_rd) begin
      sp_mask_r <= sp_mask;
      sp_addr_r <= sp_addr;
      sp_ok_r   <= sp_ok;
    end
  end

  // Result register
  assign push = cmd.emit_one | cmd.emit_zero | cmd.emit_cur;

  always_comb begin
    push_idx  = ptr_r;
    push_bits = rd_a;
    if (cmd.emit_one) begin
      push_idx  = COL_W'(1);
      push_bits = this_r;
    end
    if (cmd.emit_zero) begin
      push_idx  = '0;
      push_bits = left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else if (push) begin
      vld_out_r <= 1'b1;
    end else if (res_ready) begin
      vld_out_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      idx_out_r  <= to_out_idx(push_idx);
      bits_out_r <= to_out_bits(push_bits);
      last_out_r <= ~cmd.emit_one;
    end
  end

  assign res_valid        = vld_out_r;
  assign res_column_index = idx_out_r;
  assign res_column_bits  = bits_out_r;
  assign res_last         = last_out_r;

  // Status to the controller
  assign sts.in_spawn  = (item_cmd == CMD_SPAWN);
  assign sts.ptr_one   = (ptr_r == COL_W'(1));
  assign sts.ptr_last  = ptr_last;
  assign sts.edge_kill = edge_kill_r;
  assign sts.out_free  = ~vld_out_r | res_ready;
  assign sts.sp_more   = (sp_i_r != span);
  assign sts.kill_done = (kill_cnt_r == COL_W'(COLUMNS - 1));

endmodule

// ===== hw/rtl/lcs_controller.sv =====
module lcs_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output lcs_pkg::lcs_cmd_t cmd,
  input  lcs_pkg::lcs_sts_t sts
);
  import lcs_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_LOAD  = 10'b00_0000_0010,
    S_EMIT1 = 10'b00_0000_0100,
    S_EMIT0 = 10'b00_0000_1000,
    S_READ  = 10'b00_0001_0000,
    S_CALC  = 10'b00_0010_0000,
    S_SP_RD = 10'b00_0100_0000,
    S_SP_WR = 10'b00_1000_0000,
    S_K_RD  = 10'b01_0000_0000,
    S_K_WR  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          if (sts.in_spawn) begin
            state_nxt = S_SP_RD;
          end else if (sts.ptr_one) begin
            cmd.rd_pre = 1'b1;
            state_nxt  = S_LOAD;
          end else begin
            cmd.rd_adv = 1'b1;
            state_nxt  = S_CALC;
          end
        end
      end
      S_LOAD: begin
        cmd.ld_old = 1'b1;
        state_nxt  = S_EMIT1;
      end
      S_EMIT1: begin
        if (sts.out_free) begin
          cmd.emit_one = 1'b1;
          state_nxt    = S_EMIT0;
        end
      end
      S_EMIT0: begin
        if (sts.out_free) begin
          cmd.emit_zero = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_adv = 1'b1;
        state_nxt  = S_CALC;
      end
      S_CALC: begin
        // at pointer 1 both beats have already gone out
        if (sts.ptr_one || sts.out_free) begin
          cmd.wr_adv   = 1'b1;
          cmd.emit_cur = ~sts.ptr_one;
          state_nxt    = (sts.ptr_last && sts.edge_kill) ? S_K_RD : S_IDLE;
        end
      end
      S_SP_RD: begin
        cmd.sp_rd = 1'b1;
        state_nxt = S_SP_WR;
      end
      S_SP_WR: begin
        cmd.sp_wr = 1'b1;
        state_nxt = sts.sp_more ? S_SP_RD : S_IDLE;
      end
      S_K_RD: begin
        cmd.kill_rd = 1'b1;
        state_nxt   = S_K_WR;
      end
      S_K_WR: begin
        cmd.kill_wr = 1'b1;
        state_nxt   = sts.kill_done ? S_IDLE : S_K_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/life_column_sweep_engine.sv =====
// Advance beat when the pointer is above 1: read column and neighbour on acceptance, then
// compute and write back through the field memory's single write port, loading the result
// register there when free. Pointer 1: two result beats. Wrap with edge kill adds a read
// and a write per column. Spawn: a read and a write per ring column, 1 to 7 columns.
// Reset (synchronous, active low): every column reads dead through per-column valid bits,
// saved columns zero, pointer 1, configuration zero; no clearing pass.
module life_column_sweep_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  lcs_in_if.sink                         in_chan,
  lcs_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [lcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lcs_pkg::*;

  lcs_cmd_t cmd;
  lcs_sts_t sts;

  lcs_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  lcs_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .item_cmd         (in_chan.cmd),
    .item_spawn_col   (in_chan.spawn_col),
    .item_spawn_row   (in_chan.spawn_row),
    .item_spawn_level (in_chan.spawn_level),
    .item_random_bits (in_chan.random_bits),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .res_valid        (out_chan.valid),
    .res_column_index (out_chan.column_index),
    .res_column_bits  (out_chan.column_bits),
    .res_last         (out_chan.last),
    .res_ready        (out_chan.ready)
  );

  // A result beat is loaded only when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_one || cmd.emit_zero || cmd.emit_cur) |-> sts.out_free)
    else $error("result beat loaded over a pending one");

  // At most one result beat loaded per cycle
  a_emit_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_one, cmd.emit_zero, cmd.emit_cur}))
    else $error("two result beats loaded in one cycle");

  // The reload of the saved columns happens only at pointer 1
  a_pre_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_pre |-> sts.ptr_one)
    else $error("saved column reload away from pointer 1");

  // An accepted beat keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input taken again straight after acceptance");

endmodule
